@@ src/vsf_pkg.sv @@
`default_nettype none

package vsf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 20;
  localparam int COEF_FRAC   = 16;

  // The average quotient never exceeds one more bit than a sample.
  localparam int DIV_STEPS = SAMPLE_BITS + 1;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  localparam int TERM_BITS = 3;
  localparam int NUM_TERMS = 5;
  localparam logic [TERM_BITS-1:0] TERM_B0 = 3'd0;
  localparam logic [TERM_BITS-1:0] TERM_B1 = 3'd1;
  localparam logic [TERM_BITS-1:0] TERM_B2 = 3'd2;
  localparam logic [TERM_BITS-1:0] TERM_A1 = 3'd3;
  localparam logic [TERM_BITS-1:0] TERM_A2 = 3'd4;

  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_AVERAGE = 2'd1;
  localparam logic [1:0] MODE_BIQUAD  = 2'd2;
  localparam logic [1:0] MODE_SPARE   = 2'd3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam int REG_INDEX_BITS = 3;
  localparam logic [REG_INDEX_BITS-1:0] REG_OP_MODE   = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_SMOOTHING = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_B0   = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_B1   = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_B2   = 3'd4;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_A1   = 3'd5;
  localparam logic [REG_INDEX_BITS-1:0] REG_COEF_A2   = 3'd6;

  typedef struct packed {
    logic        [1:0]           op_mode;
    logic        [7:0]           smoothing_length_minus_one;
    logic signed [COEF_BITS-1:0] coef_b0;
    logic signed [COEF_BITS-1:0] coef_b1;
    logic signed [COEF_BITS-1:0] coef_b2;
    logic signed [COEF_BITS-1:0] coef_a1;
    logic signed [COEF_BITS-1:0] coef_a2;
  } cfg_regs_t;

  typedef struct packed {
    logic                 load;
    logic                 clear_hist;
    logic                 restart;
    logic                 ring_rd;
    logic                 evict;
    logic                 ma_add;
    logic                 div_init;
    logic                 div_step;
    logic                 mul;
    logic                 acc;
    logic [TERM_BITS-1:0] term;
    logic                 res_pass;
    logic                 res_div;
    logic                 res_bq;
    logic                 out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic evict_needed;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/vsf_datapath.sv @@
`default_nettype none

module vsf_datapath #(
  parameter int WINDOW_MAX
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire vsf_pkg::ctrl_cmd_t                       cmd,
  input  wire vsf_pkg::cfg_regs_t                       cfg,
  input  wire logic signed [vsf_pkg::SAMPLE_BITS-1:0]   sample_in,
  input  wire logic                                     out_ready,
  output vsf_pkg::dp_status_t                           status,
  output logic                                          out_valid,
  output logic signed [vsf_pkg::SAMPLE_BITS-1:0]        sample_out
);

  localparam int SB     = vsf_pkg::SAMPLE_BITS;
  localparam int AW     = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SB + CNT_W;
  localparam int MAG_W  = SUM_W - 1;
  localparam int QW     = vsf_pkg::DIV_STEPS;
  localparam int LEN_W  = (CNT_W > 9) ? CNT_W : 9;
  localparam int PW     = CNT_W + 1;
  localparam int PROD_W = vsf_pkg::COEF_BITS + SB;
  localparam int ACC_W  = PROD_W + 3;
  localparam int FRAC   = vsf_pkg::COEF_FRAC;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SB - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC - 1));

  function automatic logic signed [SB-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  logic signed [SB-1:0]     x;
  logic signed [SB-1:0]     x1;
  logic signed [SB-1:0]     x2;
  logic signed [SB-1:0]     y1;
  logic signed [SB-1:0]     y2;
  logic signed [SB-1:0]     ring [WINDOW_MAX];
  logic signed [SB-1:0]     ring_q;
  logic [AW-1:0]            wi;
  logic [CNT_W-1:0]         siw;
  logic signed [SUM_W-1:0]  sum;
  logic                     neg;
  logic [CNT_W-1:0]         rem;
  logic [QW-1:0]            dq;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SB-1:0]     res;

  logic [LEN_W-1:0]            len_full;
  logic [LEN_W-1:0]            len_cap;
  logic [PW-1:0]               wi_ext;
  logic [PW-1:0]               siw_ext;
  logic [PW-1:0]               old_full;
  logic [AW-1:0]               old_addr;
  logic [AW-1:0]               wi_inc;
  logic [SUM_W-1:0]            sum_abs;
  logic [MAG_W-1:0]            mag;
  logic [CNT_W:0]              trial;
  logic [CNT_W:0]              trial_sub;
  logic                        ge;
  logic [CNT_W-1:0]            rem_next;
  logic signed [QW:0]          q_s;
  logic signed [vsf_pkg::COEF_BITS-1:0] op_coef;
  logic signed [SB-1:0]        op_samp;
  logic                        term_sub;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [ACC_W-FRAC-1:0] y_floor;
  logic signed [SB-1:0]        y_sat;

  // Window length, capped at the ring depth.
  always_comb begin
    len_full = LEN_W'(cfg.smoothing_length_minus_one) + LEN_W'(1);
    len_cap  = (len_full > LEN_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) : len_full;
  end

  // Address of the oldest sample still in the window, modulo the ring depth.
  always_comb begin
    wi_ext   = PW'(wi);
    siw_ext  = PW'(siw);
    old_full = (siw_ext > wi_ext) ? (wi_ext + PW'(WINDOW_MAX) - siw_ext)
                                  : (wi_ext - siw_ext);
    old_addr = old_full[AW-1:0];
    wi_inc   = (wi == AW'(WINDOW_MAX - 1)) ? '0 : wi + AW'(1);
  end

  // Rounded magnitude and one restoring-division step.
  always_comb begin
    sum_abs   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    mag       = sum_abs[MAG_W-1:0] + MAG_W'(siw >> 1);
    trial     = {rem, dq[QW-1]};
    trial_sub = trial - {1'b0, siw};
    ge        = (trial >= {1'b0, siw});
    rem_next  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    q_s       = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  end

  always_comb begin
    unique case (cmd.term)
      vsf_pkg::TERM_B0: begin
        op_coef = cfg.coef_b0;
        op_samp = x;
      end
      vsf_pkg::TERM_B1: begin
        op_coef = cfg.coef_b1;
        op_samp = x1;
      end
      vsf_pkg::TERM_B2: begin
        op_coef = cfg.coef_b2;
        op_samp = x2;
      end
      vsf_pkg::TERM_A1: begin
        op_coef = cfg.coef_a1;
        op_samp = y1;
      end
      vsf_pkg::TERM_A2: begin
        op_coef = cfg.coef_a2;
        op_samp = y2;
      end
      default: begin
        op_coef = '0;
        op_samp = '0;
      end
    endcase
    term_sub = (cmd.term == vsf_pkg::TERM_A1) || (cmd.term == vsf_pkg::TERM_A2);
  end

  // Dropping the low fraction bits of a two's complement value is a floor.
  always_comb begin
    acc_r   = acc + ROUND_HALF;
    y_floor = acc_r[ACC_W-1:FRAC];
    y_sat   = sat(ACC_W'(y_floor));
  end

  assign status.evict_needed = (LEN_W'(siw) >= len_cap);
  assign status.out_busy     = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wi        <= '0;
      siw       <= '0;
      sum       <= '0;
      x1        <= '0;
      x2        <= '0;
      y1        <= '0;
      y2        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_hist) begin
        x1 <= '0;
        x2 <= '0;
        y1 <= '0;
        y2 <= '0;
      end
      if (cmd.res_bq) begin
        x2 <= x1;
        x1 <= x;
        y2 <= y1;
        y1 <= y_sat;
      end
      if (cmd.restart) begin
        siw <= '0;
        sum <= '0;
      end
      if (cmd.evict) begin
        sum <= sum - SUM_W'(ring_q);
        siw <= siw - CNT_W'(1);
      end
      if (cmd.ma_add) begin
        wi  <= wi_inc;
        sum <= sum + SUM_W'(x);
        siw <= siw + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_rd) begin
      ring_q <= ring[old_addr];
    end
    if (cmd.ma_add) begin
      ring[wi] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= sample_in;
      acc <= '0;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(op_coef) * PROD_W'(op_samp);
    end
    if (cmd.acc) begin
      acc <= term_sub ? (acc - ACC_W'(prod)) : (acc + ACC_W'(prod));
    end
    if (cmd.div_init) begin
      neg <= sum[SUM_W-1];
      rem <= CNT_W'(mag >> QW);
      dq  <= mag[QW-1:0];
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      dq  <= {dq[QW-2:0], ge};
    end
    if (cmd.res_pass) begin
      res <= x;
    end
    if (cmd.res_div) begin
      res <= sat(ACC_W'(q_s));
    end
    if (cmd.res_bq) begin
      res <= y_sat;
    end
    if (cmd.out_load) begin
      sample_out <= res;
    end
  end

  a_evict_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.evict |-> (siw != '0))
    else $error("eviction from an empty window");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    siw <= CNT_W'(WINDOW_MAX))
    else $error("window count beyond ring depth");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("result word dropped or changed while stalled");

endmodule

`default_nettype wire

@@ src/vsf_ctrl.sv @@
`default_nettype none

module vsf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                command,
  input  wire logic                first_of_buffer,
  input  wire logic [1:0]          op_mode,
  input  wire vsf_pkg::dp_status_t status,
  output logic                     in_ready,
  output vsf_pkg::ctrl_cmd_t       cmd
);

  localparam int SW = vsf_pkg::STEP_BITS;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PASS     = 4'd1;
  localparam logic [3:0] S_MA_CHK   = 4'd2;
  localparam logic [3:0] S_MA_EVICT = 4'd3;
  localparam logic [3:0] S_MA_ADD   = 4'd4;
  localparam logic [3:0] S_DIV_INIT = 4'd5;
  localparam logic [3:0] S_DIV      = 4'd6;
  localparam logic [3:0] S_DIV_FIN  = 4'd7;
  localparam logic [3:0] S_BQ_MUL   = 4'd8;
  localparam logic [3:0] S_BQ_ACC   = 4'd9;
  localparam logic [3:0] S_BQ_FIN   = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0]    state;
  logic [3:0]    state_next;
  logic [SW-1:0] step;
  logic [SW-1:0] step_next;
  logic          accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    cmd.term   = step[vsf_pkg::TERM_BITS-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == vsf_pkg::CMD_CLEAR) begin
            cmd.clear_hist = 1'b1;
          end else begin
            cmd.load    = 1'b1;
            cmd.restart = first_of_buffer;
            if (op_mode == vsf_pkg::MODE_AVERAGE) begin
              state_next = S_MA_CHK;
            end else if (op_mode == vsf_pkg::MODE_BIQUAD) begin
              state_next = S_BQ_MUL;
              step_next  = '0;
            end else begin
              state_next = S_PASS;
            end
          end
        end
      end
      S_PASS: begin
        cmd.res_pass = 1'b1;
        state_next   = S_OUT;
      end
      S_MA_CHK: begin
        // Evict one old sample per pass until there is room for the new one.
        if (status.evict_needed) begin
          cmd.ring_rd = 1'b1;
          state_next  = S_MA_EVICT;
        end else begin
          state_next = S_MA_ADD;
        end
      end
      S_MA_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = S_MA_CHK;
      end
      S_MA_ADD: begin
        cmd.ma_add = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == SW'(vsf_pkg::DIV_STEPS - 1)) begin
          state_next = S_DIV_FIN;
        end else begin
          step_next = step + SW'(1);
        end
      end
      S_DIV_FIN: begin
        cmd.res_div = 1'b1;
        state_next  = S_OUT;
      end
      S_BQ_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_BQ_ACC;
      end
      S_BQ_ACC: begin
        cmd.acc = 1'b1;
        if (step == SW'(vsf_pkg::NUM_TERMS - 1)) begin
          state_next = S_BQ_FIN;
        end else begin
          step_next  = step + SW'(1);
          state_next = S_BQ_MUL;
        end
      end
      S_BQ_FIN: begin
        cmd.res_bq = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("result word loaded over a stalled word");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (step == SW'(vsf_pkg::DIV_STEPS - 1)) |=> (state == S_DIV_FIN))
    else $error("divider did not finish after its last step");

  a_clear_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && (command == vsf_pkg::CMD_CLEAR) |=> (state == S_IDLE) && !cmd.out_load)
    else $error("clear command started work");

endmodule

`default_nettype wire

@@ src/vibration_stream_filter.sv @@
// Vibration sample filter: pass through, moving average or biquad, chosen by
// the mode register. The user writes registers via cfg_we, cfg_index and
// cfg_data only while the block is idle; the block does not enforce it.
// Input words (command, sample_in, first_of_buffer) move on in_valid and
// in_ready; result words (sample_out) move on out_valid and out_ready.
// A sample word gives one result word; a clear word gives none.
// Steps per sample word: pass through takes one result step; biquad runs
// five products through one shared multiplier, a multiply and an accumulate
// step each; moving average evicts old samples from the window (one ring
// read and one subtract each), adds the new one and then runs the
// bit-serial divider.
// Reset clears the registers, the window count, the running sum and the
// biquad history; the sample ring needs no clearing pass.
// A finished result sits in an output register, so the next input word is
// taken while it waits; if the receiver still stalls when the following
// result is ready, that result is held and no new word is accepted.
`default_nettype none

module vibration_stream_filter #(
  parameter int WINDOW_MAX = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   command,
  input  wire logic signed [vsf_pkg::SAMPLE_BITS-1:0] sample_in,
  input  wire logic                                   first_of_buffer,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [vsf_pkg::SAMPLE_BITS-1:0]      sample_out,
  input  wire logic                                   cfg_we,
  input  wire logic [vsf_pkg::REG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [vsf_pkg::COEF_BITS-1:0]          cfg_data
);

  vsf_pkg::cfg_regs_t  cfg;
  vsf_pkg::ctrl_cmd_t  cmd;
  vsf_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsf_pkg::REG_OP_MODE:   cfg.op_mode                    <= cfg_data[1:0];
        vsf_pkg::REG_SMOOTHING: cfg.smoothing_length_minus_one <= cfg_data[7:0];
        vsf_pkg::REG_COEF_B0:   cfg.coef_b0                    <= cfg_data;
        vsf_pkg::REG_COEF_B1:   cfg.coef_b1                    <= cfg_data;
        vsf_pkg::REG_COEF_B2:   cfg.coef_b2                    <= cfg_data;
        vsf_pkg::REG_COEF_A1:   cfg.coef_a1                    <= cfg_data;
        vsf_pkg::REG_COEF_A2:   cfg.coef_a2                    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vsf_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .command         (command),
    .first_of_buffer (first_of_buffer),
    .op_mode         (cfg.op_mode),
    .status          (status),
    .in_ready        (in_ready),
    .cmd             (cmd)
  );

  vsf_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .sample_in  (sample_in),
    .out_ready  (out_ready),
    .status     (status),
    .out_valid  (out_valid),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire
